// File: sv/vlf_pkg.sv
// Shared types and constants for the VLAN learning forwarder.
package vlf_pkg;

    // Defaults for the table sizes
    localparam int INGRESS_SLOTS_DEF = 64;
    localparam int PORTS_DEF         = 256;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_PROGRAM = 2'd0;
    localparam logic [1:0] OP_PHYS    = 2'd1;
    localparam logic [1:0] OP_VIRT    = 2'd2;
    localparam logic [1:0] OP_RSVD    = 2'd3;

    // Tag actions of a result transaction
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PUSH = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  slot;
        logic        slot_enable;
        logic [47:0] mac_address;
        logic [7:0]  target_port;
        logic [7:0]  arrival_port;
        logic        has_vlan;
        logic [15:0] vlan_tag_control;
        logic [15:0] vlan_protocol;
        logic [15:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic        forward;
        logic [7:0]  out_port;
        logic [1:0]  vlan_action;
        logic [15:0] push_tag_control;
        logic [15:0] push_protocol;
        logic [63:0] packet_count;
        logic [63:0] byte_count;
    } t_out_item;

    // Packet and byte counters of one table entry
    typedef struct packed {
        logic [63:0] pk;
        logic [63:0] by;
    } t_cnt;

    // Learned egress entry: where to send and which tag to push
    typedef struct packed {
        logic [7:0]  target;
        logic [15:0] tag;
        logic [15:0] proto;
    } t_eg_info;

    // Control carried from the lookup stage to the counter stage
    typedef struct packed {
        logic        prog;
        logic        phys_fwd;
        logic        virt_hit;
        logic        eg_new;
        logic [7:0]  tgt;
        logic [15:0] len;
    } t_s2_ctl;

endpackage

// File: sv/vlan_learning_forwarder_unit.sv
// Top level of the VLAN learning forwarder.
// Takes one transaction per cycle while o_stall is low and gives one result per
// transaction; the registered reads of the counter memories set the two pipeline
// stages. Stage one holds the transaction, runs the exact-match search over the
// ingress slots (lowest valid match wins), writes program slots and learned egress
// entries, and reads the counter memories; stage two adds to the counters (clears
// them on a program or a new port) and writes them back, forwarding the write of
// the previous transaction; an output register holds the result. A stall on the output
// freezes the whole pipe. No clearing pass: entry valid bits live in flip-flops.
module vlan_learning_forwarder_unit #(
    parameter int INGRESS_SLOTS = vlf_pkg::INGRESS_SLOTS_DEF,
    parameter int PORTS         = vlf_pkg::PORTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vlf_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output vlf_pkg::t_out_item o_data
);

    localparam int IW = (INGRESS_SLOTS > 1) ? $clog2(INGRESS_SLOTS) : 1;
    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

    logic adv;

    // Stage one registers and the ingress match table
    logic              r_s1_valid;
    vlf_pkg::t_in_item r_s1;
    logic              r_ing_vld [INGRESS_SLOTS];
    logic [47:0]       r_ing_key [INGRESS_SLOTS];
    logic [7:0]        r_ing_tgt [INGRESS_SLOTS];
    logic              r_eg_vld  [PORTS];

    // Stage two registers
    logic              r_s2_valid;
    vlf_pkg::t_s2_ctl  r_s2;
    logic [IW-1:0]     r_s2_ing_idx;
    logic [PW-1:0]     r_s2_eg_idx;

    // Last counter writes, for forwarding
    logic              r_lwi_v;
    logic [IW-1:0]     r_lwi_addr;
    vlf_pkg::t_cnt     r_lwi_data;
    logic              r_lwe_v;
    logic [PW-1:0]     r_lwe_addr;
    vlf_pkg::t_cnt     r_lwe_data;

    // Output register
    logic               r_o_valid;
    vlf_pkg::t_out_item r_o;
    vlf_pkg::t_out_item n_o;

    // Stage one combinational signals
    logic              found;
    logic [IW-1:0]     hit_idx;
    logic [7:0]        tgt;
    logic              phys_fwd;
    logic              t_ok;
    logic [PW-1:0]     t_idx;
    logic [PW-1:0]     a_idx;
    logic              virt_hit;
    logic              prog;
    logic [IW-1:0]     slot_idx;
    vlf_pkg::t_s2_ctl  n_s2;

    // Memory ports
    logic              ing_re;
    logic              ing_we;
    vlf_pkg::t_cnt     ing_wdata;
    vlf_pkg::t_cnt     ing_rdata;
    logic              info_we;
    logic              info_re;
    vlf_pkg::t_eg_info info_wdata;
    vlf_pkg::t_eg_info info_rdata;
    logic              egc_re;
    logic              egc_we;
    vlf_pkg::t_cnt     egc_wdata;
    vlf_pkg::t_cnt     egc_rdata;

    // Stage two combinational signals
    vlf_pkg::t_cnt     ing_base;
    vlf_pkg::t_cnt     ing_inc;
    vlf_pkg::t_cnt     eg_base;
    vlf_pkg::t_cnt     eg_inc;

    // Advance the pipe unless a held result is stalled
    assign adv     = !(r_o_valid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_o_valid;
    assign o_data  = r_o;

    // Search the ingress slots, lowest match first
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = INGRESS_SLOTS - 1; i >= 0; i--) begin
            if (r_ing_vld[i] && (r_ing_key[i] == r_s1.mac_address)) begin
                found   = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // Decode the transaction in stage one
    always_comb begin
        tgt      = r_ing_tgt[hit_idx];
        phys_fwd = r_s1_valid && (r_s1.operation == vlf_pkg::OP_PHYS)
                   && r_s1.has_vlan && found;
        t_ok     = (32'(tgt) < 32'(PORTS));
        t_idx    = PW'(tgt);
        a_idx    = PW'(r_s1.arrival_port);
        virt_hit = r_s1_valid && (r_s1.operation == vlf_pkg::OP_VIRT)
                   && (32'(r_s1.arrival_port) < 32'(PORTS)) && r_eg_vld[a_idx];
        prog     = r_s1_valid && (r_s1.operation == vlf_pkg::OP_PROGRAM)
                   && (32'(r_s1.slot) < 32'(INGRESS_SLOTS));
        slot_idx = IW'(r_s1.slot);

        n_s2.prog     = prog;
        n_s2.phys_fwd = phys_fwd;
        n_s2.virt_hit = virt_hit;
        n_s2.eg_new   = phys_fwd && t_ok && !r_eg_vld[t_idx];
        n_s2.tgt      = tgt;
        n_s2.len      = r_s1.packet_length;

        ing_re           = adv && phys_fwd;
        info_we          = adv && phys_fwd && t_ok;
        info_re          = adv && virt_hit;
        egc_re           = adv && virt_hit;
        info_wdata.target = r_s1.arrival_port;
        info_wdata.tag    = r_s1.vlan_tag_control;
        info_wdata.proto  = r_s1.vlan_protocol;
    end

    // Hold the incoming transaction in stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
        end
        if (adv) begin
            r_s1 <= i_data;
        end
    end

    // Program slots and learn egress valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < INGRESS_SLOTS; i++) begin
                r_ing_vld[i] <= 1'b0;
            end
            for (int i = 0; i < PORTS; i++) begin
                r_eg_vld[i] <= 1'b0;
            end
        end else if (adv) begin
            if (prog) begin
                r_ing_vld[slot_idx] <= r_s1.slot_enable;
            end
            if (phys_fwd && t_ok) begin
                r_eg_vld[t_idx] <= 1'b1;
            end
        end
        if (adv && prog) begin
            r_ing_key[slot_idx] <= r_s1.mac_address;
            r_ing_tgt[slot_idx] <= r_s1.target_port;
        end
    end

    // Advance to stage two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
        if (adv) begin
            r_s2         <= n_s2;
            r_s2_ing_idx <= prog ? slot_idx : hit_idx;
            r_s2_eg_idx  <= phys_fwd ? t_idx : a_idx;
        end
    end

    vlf_ram #(.WIDTH($bits(vlf_pkg::t_cnt)), .DEPTH(INGRESS_SLOTS)) u_ing_cnt (
        .i_clk   (i_clk),
        .i_we    (ing_we),
        .i_waddr (r_s2_ing_idx),
        .i_wdata (ing_wdata),
        .i_re    (ing_re),
        .i_raddr (hit_idx),
        .o_rdata (ing_rdata)
    );

    vlf_ram #(.WIDTH($bits(vlf_pkg::t_eg_info)), .DEPTH(PORTS)) u_eg_info (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (t_idx),
        .i_wdata (info_wdata),
        .i_re    (info_re),
        .i_raddr (a_idx),
        .o_rdata (info_rdata)
    );

    vlf_ram #(.WIDTH($bits(vlf_pkg::t_cnt)), .DEPTH(PORTS)) u_eg_cnt (
        .i_clk   (i_clk),
        .i_we    (egc_we),
        .i_waddr (r_s2_eg_idx),
        .i_wdata (egc_wdata),
        .i_re    (egc_re),
        .i_raddr (a_idx),
        .o_rdata (egc_rdata)
    );

    // Update counters in stage two, forwarding the previous write
    always_comb begin
        ing_base = (r_lwi_v && (r_lwi_addr == r_s2_ing_idx)) ? r_lwi_data : ing_rdata;
        ing_inc.pk = ing_base.pk + 64'd1;
        ing_inc.by = ing_base.by + 64'(r_s2.len);
        ing_we     = adv && r_s2_valid && (r_s2.prog || r_s2.phys_fwd);
        ing_wdata  = r_s2.prog ? '0 : ing_inc;

        eg_base = (r_lwe_v && (r_lwe_addr == r_s2_eg_idx)) ? r_lwe_data : egc_rdata;
        eg_inc.pk = eg_base.pk + 64'd1;
        eg_inc.by = eg_base.by + 64'(r_s2.len);
        egc_we    = adv && r_s2_valid && (r_s2.virt_hit || r_s2.eg_new);
        egc_wdata = r_s2.eg_new ? '0 : eg_inc;

        n_o = '0;
        if (r_s2.phys_fwd) begin
            n_o.forward      = 1'b1;
            n_o.out_port     = r_s2.tgt;
            n_o.vlan_action  = vlf_pkg::ACT_POP;
            n_o.packet_count = ing_inc.pk;
            n_o.byte_count   = ing_inc.by;
        end else if (r_s2.virt_hit) begin
            n_o.forward          = 1'b1;
            n_o.out_port         = info_rdata.target;
            n_o.vlan_action      = vlf_pkg::ACT_PUSH;
            n_o.push_tag_control = info_rdata.tag;
            n_o.push_protocol    = info_rdata.proto;
            n_o.packet_count     = eg_inc.pk;
            n_o.byte_count       = eg_inc.by;
        end
    end

    // Record the last counter writes and load the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lwi_v   <= 1'b0;
            r_lwe_v   <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_lwi_v   <= ing_we;
            r_lwe_v   <= egc_we;
            r_o_valid <= r_s2_valid;
        end
        if (adv) begin
            r_lwi_addr <= r_s2_ing_idx;
            r_lwi_data <= ing_wdata;
            r_lwe_addr <= r_s2_eg_idx;
            r_lwe_data <= egc_wdata;
            r_o        <= n_o;
        end
    end

`ifndef SYNTH
    a_push_forwards: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.vlan_action == vlf_pkg::ACT_PUSH)) |-> o_data.forward)
        else $error("push action on a dropped transaction");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.forward) |-> ((o_data.packet_count == 64'd0)
                                          && (o_data.byte_count == 64'd0)))
        else $error("dropped transaction carries counters");

    a_one_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(phys_fwd && virt_hit) && !(prog && phys_fwd))
        else $error("stage one decodes two operations");

    a_ingress_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_valid && r_s2.phys_fwd) |-> ing_we)
        else $error("forwarded packet left its slot counters unchanged");
`endif

endmodule

// File: sv/vlf_ram.sv
// Generic simple dual-port RAM with registered read.
module vlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
